// ----- hw/rtl/qvr_pkg.sv -----
package qvr_pkg;

    // Field and intermediate widths
    localparam int unsigned D_W  = 16;            // quaternion and vector components
    localparam int unsigned P1_W = 2 * D_W;       // q * v partial products
    localparam int unsigned T_W  = P1_W + 2;      // t = q * (0, v), sum of three products
    localparam int unsigned P2_W = T_W + D_W;     // t * conj(q) partial products
    localparam int unsigned R_W  = P2_W + 2;      // sum of four products
    localparam int unsigned N_PROD = 12;          // products per stage
    localparam int unsigned FRAC_SHIFT = 30;      // two Q1.15 factors
    localparam int unsigned SH_W = R_W - FRAC_SHIFT;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_W = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_Y = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_Z = 2'd3;

    localparam logic signed [D_W-1:0] QUAT_W_RESET = 16'sd32767;
    localparam logic signed [D_W-1:0] QUAT_V_RESET = 16'sd0;

    typedef struct packed {
        logic signed [D_W-1:0] w;
        logic signed [D_W-1:0] x;
        logic signed [D_W-1:0] y;
        logic signed [D_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [D_W-1:0] z;
        logic signed [D_W-1:0] y;
        logic signed [D_W-1:0] x;
    } vec_t;

    typedef struct packed {
        logic signed [T_W-1:0] s;
        logic signed [T_W-1:0] x;
        logic signed [T_W-1:0] y;
        logic signed [T_W-1:0] z;
    } tvec_t;

    typedef struct packed {
        logic signed [R_W-1:0] x;
        logic signed [R_W-1:0] y;
        logic signed [R_W-1:0] z;
    } rvec_t;

    typedef struct packed {
        logic                  clipped;
        logic signed [D_W-1:0] rot_z;
        logic signed [D_W-1:0] rot_y;
        logic signed [D_W-1:0] rot_x;
    } res_t;

endpackage

// ----- hw/rtl/qvr_qv_product.sv -----
// t = q * (0, v): product stage, then sum stage.
module qvr_qv_product (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qvr_pkg::vec_t  in_vec,
    input  qvr_pkg::quat_t quat,
    output logic           out_valid,
    input  logic           out_ready,
    output qvr_pkg::tvec_t out_t
);
    import qvr_pkg::*;

    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic                   s1_en;
    logic                   s2_en;
    logic signed [P1_W-1:0] prod_next [N_PROD];
    logic signed [P1_W-1:0] prod_reg  [N_PROD];
    tvec_t                  t_next;
    tvec_t                  t_reg;

    // a stage advances when it is empty or its word moves on
    assign s2_en    = !s2_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_comb begin
        prod_next[0]  = quat.x * in_vec.x;
        prod_next[1]  = quat.y * in_vec.y;
        prod_next[2]  = quat.z * in_vec.z;
        prod_next[3]  = quat.w * in_vec.x;
        prod_next[4]  = quat.y * in_vec.z;
        prod_next[5]  = quat.z * in_vec.y;
        prod_next[6]  = quat.w * in_vec.y;
        prod_next[7]  = quat.z * in_vec.x;
        prod_next[8]  = quat.x * in_vec.z;
        prod_next[9]  = quat.w * in_vec.z;
        prod_next[10] = quat.x * in_vec.y;
        prod_next[11] = quat.y * in_vec.x;
    end

    always_comb begin
        t_next.s = -(T_W'(prod_reg[0]) + T_W'(prod_reg[1]) + T_W'(prod_reg[2]));
        t_next.x = T_W'(prod_reg[3]) + T_W'(prod_reg[4]) - T_W'(prod_reg[5]);
        t_next.y = T_W'(prod_reg[6]) + T_W'(prod_reg[7]) - T_W'(prod_reg[8]);
        t_next.z = T_W'(prod_reg[9]) + T_W'(prod_reg[10]) - T_W'(prod_reg[11]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_en) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en && in_valid) begin
            prod_reg <= prod_next;
        end
        if (s2_en && s1_valid_reg) begin
            t_reg <= t_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_t     = t_reg;

endmodule

// ----- hw/rtl/qvr_tq_product.sv -----
// r = t * conj(q): product stage, then sum stage.
module qvr_tq_product (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qvr_pkg::tvec_t in_t,
    input  qvr_pkg::quat_t quat,
    output logic           out_valid,
    input  logic           out_ready,
    output qvr_pkg::rvec_t out_r
);
    import qvr_pkg::*;

    logic                   s3_valid_reg;
    logic                   s4_valid_reg;
    logic                   s3_en;
    logic                   s4_en;
    logic signed [P2_W-1:0] prod_next [N_PROD];
    logic signed [P2_W-1:0] prod_reg  [N_PROD];
    rvec_t                  r_next;
    rvec_t                  r_reg;

    assign s4_en    = !s4_valid_reg || out_ready;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign in_ready = s3_en;

    always_comb begin
        prod_next[0]  = in_t.x * quat.w;
        prod_next[1]  = in_t.s * quat.x;
        prod_next[2]  = in_t.y * quat.z;
        prod_next[3]  = in_t.z * quat.y;
        prod_next[4]  = in_t.y * quat.w;
        prod_next[5]  = in_t.s * quat.y;
        prod_next[6]  = in_t.z * quat.x;
        prod_next[7]  = in_t.x * quat.z;
        prod_next[8]  = in_t.z * quat.w;
        prod_next[9]  = in_t.s * quat.z;
        prod_next[10] = in_t.x * quat.y;
        prod_next[11] = in_t.y * quat.x;
    end

    always_comb begin
        r_next.x = R_W'(prod_reg[0]) - R_W'(prod_reg[1])
                 - R_W'(prod_reg[2]) + R_W'(prod_reg[3]);
        r_next.y = R_W'(prod_reg[4]) - R_W'(prod_reg[5])
                 - R_W'(prod_reg[6]) + R_W'(prod_reg[7]);
        r_next.z = R_W'(prod_reg[8]) - R_W'(prod_reg[9])
                 - R_W'(prod_reg[10]) + R_W'(prod_reg[11]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s3_en) begin
                s3_valid_reg <= in_valid;
            end
            if (s4_en) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_en && in_valid) begin
            prod_reg <= prod_next;
        end
        if (s4_en && s3_valid_reg) begin
            r_reg <= r_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_r     = r_reg;

endmodule

// ----- hw/rtl/qvr_round_sat.sv -----
// Round half up at 2^-30, saturate to 16 bits; holds the output word.
module qvr_round_sat (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qvr_pkg::rvec_t in_r,
    output logic           out_valid,
    input  logic           out_ready,
    output qvr_pkg::res_t  out_res
);
    import qvr_pkg::*;

    localparam logic signed [R_W-1:0]  HALF    = R_W'(64'sd1 <<< (FRAC_SHIFT - 1));
    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(32768);

    logic  valid_reg;
    logic  s5_en;
    logic  sat_x;
    logic  sat_y;
    logic  sat_z;
    res_t  res_next;
    res_t  res_reg;

    function automatic logic signed [D_W-1:0] round_sat(
        input  logic signed [R_W-1:0] acc,
        output logic                  sat
    );
        logic signed [R_W-1:0]  biased;
        logic signed [SH_W-1:0] q;
        biased = acc + HALF;
        q      = biased[R_W-1:FRAC_SHIFT];
        sat    = 1'b0;
        if (q > SAT_MAX) begin
            sat = 1'b1;
            return SAT_MAX[D_W-1:0];
        end else if (q < SAT_MIN) begin
            sat = 1'b1;
            return SAT_MIN[D_W-1:0];
        end
        return q[D_W-1:0];
    endfunction

    assign s5_en    = !valid_reg || out_ready;
    assign in_ready = s5_en;

    always_comb begin
        res_next.rot_x   = round_sat(in_r.x, sat_x);
        res_next.rot_y   = round_sat(in_r.y, sat_y);
        res_next.rot_z   = round_sat(in_r.z, sat_z);
        res_next.clipped = sat_x | sat_y | sat_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s5_en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_en && in_valid) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- hw/rtl/quaternion_vector_rotation.sv -----
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: vec_x, vec_y, vec_z
// m_        out  m_tvalid/m_tready  m_tdata: rot_x, rot_y, rot_z; m_tuser: clipped
// cfg_      in   cfg_wr_en          cfg_addr 0..3 = quat_w, quat_x, quat_y, quat_z
//
// One word per cycle sustained while m_tready is high; from accept to m_tvalid a word passes
// through the product, sum, product, sum and round/saturate registers.
// Synchronous active-low reset empties the pipeline and loads quat = (32767, 0, 0, 0).
// Each stage advances when empty or when its word moves on, so bubbles close
// up under a stall and s_tready stays high while m_tvalid is low.
module quaternion_vector_rotation (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [qvr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [qvr_pkg::D_W-1:0]             cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,   // vec_x, vec_y, vec_z
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // rot_x, rot_y, rot_z
    output logic                                m_tuser    // clipped
);
    import qvr_pkg::*;

    quat_t quat_reg;
    vec_t  in_vec;
    tvec_t t_vec;
    rvec_t r_vec;
    res_t  res;
    logic  t_valid;
    logic  t_ready;
    logic  r_valid;
    logic  r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg.w <= QUAT_W_RESET;
            quat_reg.x <= QUAT_V_RESET;
            quat_reg.y <= QUAT_V_RESET;
            quat_reg.z <= QUAT_V_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_QUAT_W: quat_reg.w <= cfg_wdata;
                REG_QUAT_X: quat_reg.x <= cfg_wdata;
                REG_QUAT_Y: quat_reg.y <= cfg_wdata;
                REG_QUAT_Z: quat_reg.z <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_vec = s_tdata;

    qvr_qv_product u_qv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_vec    (in_vec),
        .quat      (quat_reg),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_t     (t_vec)
    );

    qvr_tq_product u_tq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_t      (t_vec),
        .quat      (quat_reg),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_r     (r_vec)
    );

    qvr_round_sat u_rs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_r      (r_vec),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.rot_z, res.rot_y, res.rot_x};
    assign m_tuser = res.clipped;

endmodule

// ----- hw/rtl/qvr_checker.sv -----
module qvr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // clipped means at least one component sits on a rail
    a_clip_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 ||
            m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000 ||
            m_tdata[47:32] == 16'h7fff || m_tdata[47:32] == 16'h8000)
        else $error("clipped set with no saturated component");

    // empty output means bubbles ahead, so input is open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
